@@ design/swrl_pkg.sv @@
`default_nettype none

package swrl_pkg;

  // Depth of the timestamp log, one cell per stored stamp.
  localparam int STORE_DEPTH = 64;

  localparam int STAMP_W    = 32;
  localparam int COUNT_W    = $clog2(STORE_DEPTH + 1);
  localparam int MAX_W      = 7;
  localparam int RETRY_W    = 23;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Division by 1000 as a multiply by ceil(2^38 / 1000) and a shift by 38.
  // This is exact for every 32-bit dividend.
  localparam int RECIP_W   = 29;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;
  localparam int DIV_SHIFT = 38;
  localparam int PROD_W    = STAMP_W + RECIP_W;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS = 1'b1;

  localparam logic [STAMP_W-1:0] WINDOW_RESET = 32'd60000;
  localparam logic [MAX_W-1:0]   MAX_RESET    = 7'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUSH,
    ST_SCALE,
    ST_EMIT
  } state_t;

  // Commands from the controller to the row of cells.
  typedef struct packed {
    logic shift;
    logic append;
  } chain_ctrl_t;

endpackage

`default_nettype wire

@@ design/swrl_cell.sv @@
`default_nettype none

module swrl_cell
  import swrl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               shift,
  input  wire logic               load,
  input  wire logic [STAMP_W-1:0] neighbor_stamp,
  input  wire logic [STAMP_W-1:0] new_stamp,
  output logic      [STAMP_W-1:0] stamp
);

  logic [STAMP_W-1:0] stamp_next;

  always_comb begin
    stamp_next = stamp;
    if (load) begin
      stamp_next = new_stamp;
    end else if (shift) begin
      stamp_next = neighbor_stamp;
    end
  end

  always_ff @(posedge clk) begin
    stamp <= stamp_next;
  end

endmodule

`default_nettype wire

@@ design/swrl_chain.sv @@
`default_nettype none

module swrl_chain
  import swrl_pkg::*;
(
  input  wire logic               clk,
  input  wire chain_ctrl_t        ctrl,
  input  wire logic [COUNT_W-1:0] entry_count,
  input  wire logic [STAMP_W-1:0] new_stamp,
  output logic      [STAMP_W-1:0] head_stamp
);

  // Cell 0 holds the oldest stamp; a pop moves every stamp one cell down.
  logic [STAMP_W-1:0] cell_stamp [STORE_DEPTH];

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    logic [STAMP_W-1:0] right;
    logic               load;

    if (i == STORE_DEPTH - 1) begin : g_last
      assign right = cell_stamp[i];
    end else begin : g_mid
      assign right = cell_stamp[i+1];
    end

    // The first free cell takes the new stamp.
    assign load = ctrl.append && (entry_count == COUNT_W'(i));

    swrl_cell u_cell (
      .clk            (clk),
      .shift          (ctrl.shift),
      .load           (load),
      .neighbor_stamp (right),
      .new_stamp      (new_stamp),
      .stamp          (cell_stamp[i])
    );
  end

  assign head_stamp = cell_stamp[0];

endmodule

`default_nettype wire

@@ design/sliding_window_rate_limiter.sv @@
// Sliding-window request rate limiter.
// Input channel: in_valid/in_stall carry one request item, now_ms, a
// free-running millisecond stamp. Output channel: out_valid/out_stall carry
// one result item per request: allowed, and retry_after_s (0 when allowed).
// Registers window_ms (index 0) and max_requests (index 1) are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while
// no request is in flight, and the block itself does not enforce this.
// The log of stamps lives in a row of 64 cells; each cycle it can drop its
// oldest stamp (every cell takes its neighbor's stamp) or append one.
// An accepted request pops its expired stamps, one per cycle; an allowed
// one then appends its stamp, a rejected one pops the oldest, appends its
// own and goes through a subtract stage and a registered reciprocal
// multiply. The result is registered and shows on the output in the cycle
// after it is issued. Reset empties the log and restores window_ms =
// 60000, max_requests = 10. While the receiver stalls, the result holds
// in its output register; the block may take the next request and works
// it up to issuing its result and waits there for the register to free up.
`default_nettype none

module sliding_window_rate_limiter
  import swrl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [STAMP_W-1:0]    now_ms,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       allowed,
  output logic      [RETRY_W-1:0]    retry_after_s,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [STAMP_W-1:0] window_ms;
  logic [MAX_W-1:0]   max_requests;
  logic [COUNT_W-1:0] entry_count;
  logic [STAMP_W-1:0] now_q;
  logic [STAMP_W-1:0] cutoff;
  logic [STAMP_W-1:0] diff;
  logic [PROD_W-1:0]  product;

  logic [STAMP_W-1:0] head_stamp;
  logic [STAMP_W-1:0] oldest;
  logic [COUNT_W-1:0] limit;
  chain_ctrl_t        ctrl;
  logic               in_accept;
  logic               out_free;
  logic               expire;
  logic               over;
  logic               emit_allow;
  logic               emit_reject;
  logic               diff_load;
  logic               prod_load;

  assign in_stall  = rst || (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Zero acts as one and anything above the depth acts as the depth.
  always_comb begin
    if (max_requests == '0) begin
      limit = COUNT_W'(1);
    end else if ({{COUNT_W{1'b0}}, max_requests} > (COUNT_W + MAX_W)'(STORE_DEPTH)) begin
      limit = COUNT_W'(STORE_DEPTH);
    end else begin
      limit = COUNT_W'(max_requests);
    end
  end

  assign expire = (entry_count != '0) && (head_stamp <= cutoff);
  assign over   = (entry_count >= limit);

  // After the reject pop an empty log means the new stamp is the oldest.
  assign oldest = (entry_count == '0) ? now_q : head_stamp;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (expire) begin
          state_next = ST_SCAN;
        end else if (over) begin
          state_next = ST_PUSH;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_PUSH:  state_next = ST_SCALE;
      ST_SCALE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl        = '0;
    emit_allow  = 1'b0;
    emit_reject = 1'b0;
    diff_load   = 1'b0;
    prod_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
      end
      ST_SCAN: begin
        if (expire || over) begin
          ctrl.shift = 1'b1;
        end else if (out_free) begin
          ctrl.append = 1'b1;
          emit_allow  = 1'b1;
        end
      end
      ST_PUSH: begin
        ctrl.append = 1'b1;
        diff_load   = 1'b1;
      end
      ST_SCALE: prod_load = 1'b1;
      ST_EMIT:  emit_reject = out_free;
      default: begin
      end
    endcase
  end

  swrl_chain u_chain (
    .clk         (clk),
    .ctrl        (ctrl),
    .entry_count (entry_count),
    .new_stamp   (now_q),
    .head_stamp  (head_stamp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      entry_count  <= '0;
      window_ms    <= WINDOW_RESET;
      max_requests <= MAX_RESET;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_MS:    window_ms    <= cfg_data[STAMP_W-1:0];
          REG_MAX_REQUESTS: max_requests <= cfg_data[MAX_W-1:0];
          default: begin
          end
        endcase
      end
      if (ctrl.shift) begin
        entry_count <= entry_count - COUNT_W'(1);
      end else if (ctrl.append) begin
        entry_count <= entry_count + COUNT_W'(1);
      end
      if (emit_allow || emit_reject) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      now_q  <= now_ms;
      cutoff <= now_ms - window_ms;
    end
    if (diff_load) begin
      diff <= window_ms - (now_q - oldest);
    end
    if (prod_load) begin
      product <= PROD_W'(diff) * PROD_W'(RECIP_1000);
    end
    if (emit_allow) begin
      allowed       <= 1'b1;
      retry_after_s <= '0;
    end else if (emit_reject) begin
      allowed       <= 1'b0;
      retry_after_s <= product[DIV_SHIFT +: RETRY_W] + RETRY_W'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= COUNT_W'(STORE_DEPTH))
    else $error("log holds more stamps than the store depth");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_SCAN))
    else $error("accepted item did not start the expiry scan");

  a_allow_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && allowed) |-> (retry_after_s == '0))
    else $error("allowed item carries a nonzero retry time");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.append |=> (entry_count == $past(entry_count) + COUNT_W'(1)))
    else $error("append did not grow the log by one");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (emit_allow || emit_reject) |-> out_free)
    else $error("result issued over an unaccepted one");

endmodule

`default_nettype wire
